@@ src/tisp_pkg.sv @@
// Shared types, character codes and constants for the time interval string parser.
package tisp_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_Y     = 8'h79;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_H     = 8'h68;
  localparam logic [7:0] CHAR_M     = 8'h6d;
  localparam logic [7:0] CHAR_S     = 8'h73;

  // largest value that can still take another digit without passing 2^32-1
  localparam logic [31:0] DIGIT_LIMIT     = 32'd429496729;
  localparam logic [3:0]  DIGIT_LIMIT_REM = 4'd5;

  localparam logic [2:0] SUM_LAST = 3'd6;

  typedef enum logic [3:0] {
    CH_DIGIT,
    CH_Y,
    CH_D,
    CH_H,
    CH_M,
    CH_S,
    CH_COLON,
    CH_MINUS,
    CH_NUL,
    CH_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    UNIT_NONE,
    UNIT_Y,
    UNIT_D,
    UNIT_H,
    UNIT_S,
    UNIT_MS
  } unit_t;

  typedef struct packed {
    logic  digit_push;
    logic  zero_base;   // digit value restarts from zero for this byte
    logic  store_min;
    unit_t unit;
    logic  set_neg;
    logic  fin;
    logic  fin_ok;
    logic  sum_step;
    logic  load;
  } tisp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        ovf;
    logic        sum_last;
    logic        out_free;
  } tisp_stat_t;

  // multiplier applied to the running total at each sum step
  function automatic logic [9:0] sum_mult(input logic [2:0] step);
    logic [9:0] m;
    unique case (step)
      3'd0:    m = 10'd365;
      3'd1:    m = 10'd24;
      3'd2:    m = 10'd60;
      3'd3:    m = 10'd60;
      default: m = 10'd1000;
    endcase
    return m;
  endfunction

endpackage

@@ src/tisp_ctrl.sv @@
// Controller: parse phases, final sum sequencing and result hand-off.
module tisp_ctrl
  import tisp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tisp_stat_t stat,
  output tisp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_START,
    S_BODY,
    S_AFTER_UNIT,
    S_AFTER_M,
    S_ERROR,
    S_SUM,
    S_HOLD
  } state_t;

  state_t    state, state_next;
  tisp_cmd_t body_cmd;
  state_t    body_state;
  logic      zb;
  logic      acc;

  assign in_ready = (state != S_SUM) && (state != S_HOLD);
  assign acc      = in_valid && in_ready;
  assign zb       = (state == S_AFTER_UNIT) || (state == S_AFTER_M);

  // handling of an ordinary body byte, shared by several phases
  always_comb begin
    body_cmd           = '0;
    body_cmd.unit      = UNIT_NONE;
    body_cmd.zero_base = zb;
    body_state         = S_BODY;
    unique case (stat.cls)
      CH_DIGIT: begin
        if (stat.ovf && !zb) begin
          body_state = S_ERROR;
        end else begin
          body_cmd.digit_push = 1'b1;
        end
      end
      CH_Y: begin body_cmd.unit = UNIT_Y; body_state = S_AFTER_UNIT; end
      CH_D: begin body_cmd.unit = UNIT_D; body_state = S_AFTER_UNIT; end
      CH_H: begin body_cmd.unit = UNIT_H; body_state = S_AFTER_UNIT; end
      CH_S: begin body_cmd.unit = UNIT_S; body_state = S_AFTER_UNIT; end
      CH_M: body_state = S_AFTER_M;
      CH_NUL: begin
        body_cmd.fin = 1'b1;
        body_state   = S_HOLD;
      end
      default: body_state = S_ERROR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.unit   = UNIT_NONE;
    state_next = state;
    unique case (state)
      S_START: begin
        if (acc) begin
          if (stat.cls == CH_MINUS) begin
            cmd.set_neg = 1'b1;
            state_next  = S_BODY;
          end else begin
            cmd        = body_cmd;
            state_next = body_state;
          end
        end
      end
      S_BODY: begin
        if (acc) begin
          cmd        = body_cmd;
          state_next = body_state;
        end
      end
      S_AFTER_UNIT, S_AFTER_M: begin
        if (acc) begin
          if (state == S_AFTER_M && stat.cls == CH_S) begin
            cmd.unit   = UNIT_MS;
            state_next = S_AFTER_UNIT;
          end else if (stat.cls == CH_NUL) begin
            cmd.store_min = (state == S_AFTER_M);
            cmd.fin       = 1'b1;
            cmd.fin_ok    = 1'b1;
            state_next    = S_SUM;
          end else if (stat.cls == CH_COLON) begin
            cmd.store_min = (state == S_AFTER_M);
            cmd.zero_base = 1'b1;
            state_next    = S_BODY;
          end else begin
            cmd           = body_cmd;
            cmd.store_min = (state == S_AFTER_M);
            state_next    = body_state;
          end
        end
      end
      S_ERROR: begin
        if (acc && stat.cls == CH_NUL) begin
          cmd.fin    = 1'b1;
          state_next = S_HOLD;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_last) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      default: state_next = S_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/tisp_dpath.sv @@
// Datapath: character decode, digit accumulator, unit counts, sum unit, result register.
module tisp_dpath
  import tisp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  tisp_cmd_t   cmd,
  output tisp_stat_t  stat,
  input  logic        res_ready,
  output logic        res_valid,
  output logic        parse_ok,
  output logic [63:0] time_us
);

  char_class_t cls;
  logic [3:0]  digit;
  logic [31:0] base;
  logic [31:0] digit_value, digit_next;
  logic        negative_flag;
  logic [31:0] year_count, day_count, hour_count, minute_count, second_count, milli_count;
  logic [63:0] sum_acc;
  logic [2:0]  sum_idx;
  logic [31:0] addend;
  logic [63:0] prod;
  logic        res_ok;
  logic        out_free;

  always_comb begin
    if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      cls = CH_DIGIT;
    end else begin
      unique case (char_code)
        CHAR_Y:     cls = CH_Y;
        CHAR_D:     cls = CH_D;
        CHAR_H:     cls = CH_H;
        CHAR_M:     cls = CH_M;
        CHAR_S:     cls = CH_S;
        CHAR_COLON: cls = CH_COLON;
        CHAR_MINUS: cls = CH_MINUS;
        CHAR_NUL:   cls = CH_NUL;
        default:    cls = CH_OTHER;
      endcase
    end
  end

  assign digit      = 4'(char_code - CHAR_ZERO);
  assign base       = cmd.zero_base ? 32'd0 : digit_value;
  assign digit_next = (base << 3) + (base << 1) + {28'd0, digit};

  assign out_free = !res_valid || res_ready;

  assign stat.cls      = cls;
  assign stat.ovf      = (digit_value > DIGIT_LIMIT) ||
                         ((digit_value == DIGIT_LIMIT) && (digit > DIGIT_LIMIT_REM));
  assign stat.sum_last = (sum_idx == SUM_LAST);
  assign stat.out_free = out_free;

  always_comb begin
    unique case (sum_idx)
      3'd0:    addend = day_count;
      3'd1:    addend = hour_count;
      3'd2:    addend = minute_count;
      3'd3:    addend = second_count;
      3'd4:    addend = milli_count;
      default: addend = 32'd0;
    endcase
  end

  assign prod = sum_acc * {54'd0, sum_mult(sum_idx)};

  // parse state
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      negative_flag <= 1'b0;
      digit_value   <= '0;
      year_count    <= '0;
      day_count     <= '0;
      hour_count    <= '0;
      minute_count  <= '0;
      second_count  <= '0;
      milli_count   <= '0;
    end else begin
      if (cmd.set_neg) begin
        negative_flag <= 1'b1;
      end
      if (cmd.digit_push) begin
        digit_value <= digit_next;
      end else if (cmd.zero_base) begin
        digit_value <= '0;
      end
      if (cmd.store_min) begin
        minute_count <= digit_value;
      end
      unique case (cmd.unit)
        UNIT_Y:  year_count   <= base;
        UNIT_D:  day_count    <= base;
        UNIT_H:  hour_count   <= base;
        UNIT_S:  second_count <= base;
        UNIT_MS: milli_count  <= base;
        default: ;
      endcase
    end
  end

  // sum unit: one multiply-add per cycle, then the sign
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      sum_acc <= {32'd0, year_count};
      sum_idx <= '0;
      res_ok  <= cmd.fin_ok;
    end else if (cmd.sum_step) begin
      sum_idx <= sum_idx + 3'd1;
      if (sum_idx == SUM_LAST) begin
        sum_acc <= negative_flag ? (64'd0 - sum_acc) : sum_acc;
      end else begin
        sum_acc <= prod + {32'd0, addend};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      parse_ok <= res_ok;
      time_us  <= res_ok ? sum_acc : 64'd0;
    end
  end

endmodule

@@ src/time_interval_string_parser_core.sv @@
// Ordinary bytes are accepted back to back.
// A terminator after a good string runs the sum unit (one multiply-add per cycle,
// then the sign) and then loads the result into the output register; a failed
// string loads its result without the sum unit. No byte is taken meanwhile.
// The result sits in an output register; the next string may start while it waits.
// Synchronous active-high reset clears the parser to the start of a string.
module time_interval_string_parser_core
  import tisp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] time_us
  output logic [0:0]  m_axis_tuser    // [0] parse_ok
);

  tisp_cmd_t  cmd;
  tisp_stat_t stat;
  logic       ok;

  tisp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tisp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .char_code (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .res_ready (m_axis_tready),
    .res_valid (m_axis_tvalid),
    .parse_ok  (ok),
    .time_us   (m_axis_tdata)
  );

  assign m_axis_tuser = ok;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the time interval string parser core.
module testbench
  import tisp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SETTLE_TICKS = 16;   // extra wait after the last pending total has come back

  typedef enum logic [2:0] {
    PH_START,
    PH_BODY,
    PH_AFTER_UNIT,
    PH_AFTER_M,
    PH_ERROR
  } parse_phase_t;

  typedef enum logic [2:0] {
    F_YEAR,
    F_DAY,
    F_HOUR,
    F_MIN,
    F_SEC,
    F_MILLI
  } time_field_t;

  typedef struct {
    logic        ok;
    logic [63:0] us;
  } interval_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // [63:0] time_us
  logic [0:0]  m_axis_tuser;    // [0] parse_ok

  // parser shadow state
  parse_phase_t phase;
  logic         neg;
  logic [31:0]  acc;
  logic [31:0]  yr_cnt, day_cnt, hr_cnt, min_cnt, sec_cnt, ms_cnt;

  interval_t expected_totals[$];
  interval_t head;

  int  errors;
  int  cycles;
  int  chars_taken;
  int  chars_ignored;
  int  totals_checked;
  int  stall_left;
  bit  src_idle;
  bit  sink_idle;

  time_interval_string_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d totals outstanding", cycles,
               expected_totals.size());
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser();
    phase   = PH_START;
    neg     = 1'b0;
    acc     = '0;
    yr_cnt  = '0;
    day_cnt = '0;
    hr_cnt  = '0;
    min_cnt = '0;
    sec_cnt = '0;
    ms_cnt  = '0;
  endfunction

  function automatic void settle_total(input bit ok);
    logic [63:0] t;
    interval_t   r;
    t = '0;
    if (ok) begin
      t = 64'(yr_cnt) * 64'd365 + 64'(day_cnt);
      t = t * 64'd24 + 64'(hr_cnt);
      t = t * 64'd60 + 64'(min_cnt);
      t = t * 64'd60 + 64'(sec_cnt);
      t = t * 64'd1000 + 64'(ms_cnt);
      t = t * 64'd1000;
      if (neg) t = -t;
    end
    r.ok = ok;
    r.us = t;
    expected_totals.push_back(r);
    clear_parser();
  endfunction

  function automatic void body_char(input logic [7:0] c);
    logic [3:0] d;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 4'(c - CHAR_ZERO);
      if (acc < DIGIT_LIMIT || (acc == DIGIT_LIMIT && d <= DIGIT_LIMIT_REM))
        acc = acc * 10 + 32'(d);
      else
        phase = PH_ERROR;
    end else begin
      case (c)
        CHAR_Y: begin
          yr_cnt = acc;
          phase  = PH_AFTER_UNIT;
        end
        CHAR_D: begin
          day_cnt = acc;
          phase   = PH_AFTER_UNIT;
        end
        CHAR_H: begin
          hr_cnt = acc;
          phase  = PH_AFTER_UNIT;
        end
        CHAR_S: begin
          sec_cnt = acc;
          phase   = PH_AFTER_UNIT;
        end
        CHAR_M:   phase = PH_AFTER_M;
        CHAR_NUL: settle_total(1'b0);
        default:  phase = PH_ERROR;
      endcase
    end
  endfunction

  function automatic void after_unit_char(input logic [7:0] c);
    if (c == CHAR_NUL) begin
      settle_total(1'b1);
    end else begin
      acc   = '0;
      phase = PH_BODY;
      if (c != CHAR_COLON) body_char(c);
    end
  endfunction

  // returns 1 when the byte only gets skipped in the error state
  function automatic bit step_parser(input logic [7:0] c);
    bit ignored;
    ignored = 1'b0;
    case (phase)
      PH_START: begin
        phase = PH_BODY;
        if (c == CHAR_MINUS) neg = 1'b1;
        else body_char(c);
      end
      PH_BODY:       body_char(c);
      PH_AFTER_UNIT: after_unit_char(c);
      PH_AFTER_M: begin
        // 'm' is minutes unless an 's' follows
        if (c == CHAR_S) begin
          ms_cnt = acc;
          phase  = PH_AFTER_UNIT;
        end else begin
          min_cnt = acc;
          after_unit_char(c);
        end
      end
      default: begin
        phase   = PH_ERROR;
        ignored = (c != CHAR_NUL);
        if (c == CHAR_NUL) settle_total(1'b0);
      end
    endcase
    return ignored;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ok=%0b us=%0d", $time,
                 m_axis_tuser[0], $signed(m_axis_tdata));
        errors++;
      end else begin
        head = expected_totals.pop_front();
        if (m_axis_tuser[0] !== head.ok) begin
          $display("%0t: parse_ok mismatch, expected %0b, got %0b", $time, head.ok,
                   m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata !== head.us) begin
          $display("%0t: time_us mismatch, expected %0d, got %0d", $time,
                   $signed(head.us), $signed(m_axis_tdata));
          errors++;
        end
        totals_checked++;
      end
    end
  end

  // result-side backpressure
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (sink_idle && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    if (step_parser(c)) chars_ignored++;
    else chars_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_number(input longint unsigned v, input int pad);
    logic [7:0]        digs[$];
    longint unsigned   r;
    r = v;
    do begin
      digs.push_front(CHAR_ZERO + 8'(r % 10));
      r = r / 10;
    end while (r != 0);
    repeat (pad) digs.push_front(CHAR_ZERO);
    foreach (digs[i]) send_char(digs[i]);
  endtask

  task automatic send_unit(input time_field_t f);
    case (f)
      F_YEAR: send_char(CHAR_Y);
      F_DAY:  send_char(CHAR_D);
      F_HOUR: send_char(CHAR_H);
      F_MIN:  send_char(CHAR_M);
      F_SEC:  send_char(CHAR_S);
      default: begin
        send_char(CHAR_M);
        send_char(CHAR_S);
      end
    endcase
  endtask

  function automatic longint unsigned pick_value();
    case ($urandom_range(0, 19))
      0:       return 64'hFFFF_FFFF;
      1:       return 64'd4294967290 + $urandom_range(0, 5);   // near the top
      2, 3, 4: return 64'($urandom);
      5:       return 64'd0;
      default: return 64'($urandom_range(0, 999));
    endcase
  endfunction

  task automatic inject_fault();
    case ($urandom_range(0, 4))
      0: send_number(64'd4294967296 + $urandom_range(0, 99999), 0);   // digit overflow
      1: send_char(8'($urandom_range(1, 255)));
      2: send_text("::");
      3: send_char(CHAR_MINUS);
      default: send_number(pick_value(), 0);
    endcase
  endtask

  task automatic send_interval(input bit broken);
    int          n;
    int          fault_at;
    time_field_t f;
    if ($urandom_range(0, 2) == 0) send_char(CHAR_MINUS);
    n        = $urandom_range(1, 6);
    fault_at = broken ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == fault_at) inject_fault();
      if ($urandom_range(0, 9) != 0)
        send_number(pick_value(), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
      f = time_field_t'($urandom_range(0, 5));
      send_unit(f);
      if (i != n - 1 && $urandom_range(0, 1) == 1) send_char(CHAR_COLON);
    end
    if (fault_at == n) inject_fault();
    send_char(CHAR_NUL);
  endtask

  // hold off the sender until every pending total has come back
  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_char(CHAR_NUL);          // empty string
    send_text("-");               // sign only
    send_char(CHAR_NUL);
    send_text("h2h");             // bare unit, then the same unit again
    send_char(CHAR_NUL);
    send_text("-m:7ms");          // m closed by a colon, then ms
    send_char(CHAR_NUL);
    send_text("5s:");             // ends on a colon
    send_char(CHAR_NUL);
    send_text("4294967296");      // overflow, rest is skipped
    send_char(8'hFF);
    send_char(CHAR_NUL);
    send_text("1-");              // minus in the middle
    send_char(CHAR_NUL);
  endtask

  // byte budgets count every transfer, skipped ones included
  task automatic test_intervals(input int n);
    int start;
    start = chars_taken + chars_ignored;
    while (chars_taken + chars_ignored - start < n) send_interval($urandom_range(0, 5) == 0);
  endtask

  task automatic test_noise(input int n);
    int start;
    start = chars_taken + chars_ignored;
    while (chars_taken + chars_ignored - start < n) begin
      case ($urandom_range(0, 7))
        0:       send_char(CHAR_NUL);
        1:       send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        2:       send_unit(time_field_t'($urandom_range(0, 5)));
        3:       send_char($urandom_range(0, 1) ? CHAR_COLON : CHAR_MINUS);
        default: send_char(8'($urandom_range(0, 255)));
      endcase
    end
    send_char(CHAR_NUL);
  endtask

  task automatic test_full_rate(input int n);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    test_intervals(n);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    errors        = 0;
    cycles        = 0;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_drain();
    test_intervals(500);
    wait_drain();
    test_noise(150);
    wait_drain();
    test_full_rate(150);
    wait_drain();

    if (expected_totals.size() != 0) begin
      $display("%0t: %0d totals never arrived", $time, expected_totals.size());
      errors++;
    end
    $display("sent %0d string bytes (%0d more skipped after errors), checked %0d totals",
             chars_taken, chars_ignored, totals_checked);
    $display("mix: directed corner strings, random intervals with faults, byte noise");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tisp_pkg.sv
src/tisp_ctrl.sv
src/tisp_dpath.sv
src/time_interval_string_parser_core.sv
test/testbench.sv
